// ===== src/oefs_pkg.sv =====
// ----------------------------------------------------------------------------
// oefs_pkg: shared constants and types for the eccentricity pipeline
// Fixed field widths, fixed-point defaults and the reset value of mu.
// ----------------------------------------------------------------------------
package oefs_pkg;

  localparam int POS_FRAC_DEF = 8;
  localparam int VEL_FRAC_DEF = 16;
  localparam int ECC_FRAC_DEF = 24;

  localparam int MU_FRAC_BITS = 8;
  localparam int NORM_GUARD   = 30;

  localparam int COMP_W = 32;
  localparam int MU_W   = 48;
  // quotient bits kept by each divider; anything larger saturates
  localparam int QUO_W  = 34;

  localparam logic [MU_W-1:0] MU_RESET = 48'd102041713;

  typedef logic signed [COMP_W-1:0] comp_t;

endpackage

// ===== src/oefs_sqrt.sv =====
// ----------------------------------------------------------------------------
// oefs_sqrt: pipelined integer square root
// Restoring digit-by-digit root, one result bit per register stage.
// ----------------------------------------------------------------------------
module oefs_sqrt #(
  parameter int IW = 66
) (
  input  logic            clk,
  input  logic            en,
  input  logic [IW-1:0]   x,
  output logic [IW/2-1:0] root
);

  localparam int RW = IW / 2;

  logic [RW:0]   rem_q  [1:RW];
  logic [RW-1:0] root_q [1:RW];
  logic [IW-1:0] x_q    [1:RW];

  for (genvar g = 0; g < RW; g++) begin : g_step
    logic [RW:0]   rem_i;
    logic [RW-1:0] root_i;
    logic [IW-1:0] x_i;
    logic [RW+2:0] trial;
    logic [RW+2:0] sub;
    logic [RW+2:0] diff;
    logic          take;

    if (g == 0) begin : g_first
      assign rem_i  = '0;
      assign root_i = '0;
      assign x_i    = x;
    end else begin : g_rest
      assign rem_i  = rem_q[g];
      assign root_i = root_q[g];
      assign x_i    = x_q[g];
    end

    assign trial = {rem_i, x_i[IW-1 -: 2]};
    assign sub   = {1'b0, root_i, 2'b01};
    assign diff  = trial - sub;
    assign take  = (trial >= sub);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[g+1]  <= take ? diff[RW:0] : trial[RW:0];
        root_q[g+1] <= {root_i[RW-2:0], take};
        x_q[g+1]    <= {x_i[IW-3:0], 2'b00};
      end
    end
  end

  assign root = root_q[RW];

endmodule

// ===== src/oefs_div.sv =====
// ----------------------------------------------------------------------------
// oefs_div: pipelined unsigned divider with saturating quotient
// One overflow-check stage, then one restoring quotient bit per stage.
// ----------------------------------------------------------------------------
module oefs_div #(
  parameter int NW = 98,
  parameter int DW = 56,
  parameter int QW = 34,
  parameter int TW = 1
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] n,
  input  logic [DW-1:0] d,
  input  logic [TW-1:0] tag_in,
  output logic [QW-1:0] q,
  output logic [TW-1:0] tag_out
);

  localparam int CW = ((NW - QW) > DW) ? (NW - QW) : DW;

  logic [DW-1:0] r_q    [0:QW-1];
  logic [QW-1:0] nlow_q [0:QW-1];
  logic [DW-1:0] d_q    [0:QW-1];
  logic [QW-1:0] q_q    [0:QW];
  logic          ovf_q  [0:QW];
  logic [TW-1:0] tag_q  [0:QW];

  logic [CW-1:0] top_e;
  logic [CW-1:0] d_e;

  assign top_e = CW'(n >> QW);
  assign d_e   = CW'(d);

  // quotient fits in QW bits exactly when the upper part is below d
  always_ff @(posedge clk) begin
    if (en) begin
      ovf_q[0]  <= (top_e >= d_e);
      r_q[0]    <= DW'(n >> QW);
      nlow_q[0] <= n[QW-1:0];
      d_q[0]    <= d;
      q_q[0]    <= '0;
      tag_q[0]  <= tag_in;
    end
  end

  for (genvar g = 0; g < QW; g++) begin : g_step
    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        take;

    assign trial = {r_q[g], nlow_q[g][QW-1]};
    assign diff  = trial - {1'b0, d_q[g]};
    assign take  = (trial >= {1'b0, d_q[g]});

    always_ff @(posedge clk) begin
      if (en) begin
        q_q[g+1]   <= {q_q[g][QW-2:0], take};
        ovf_q[g+1] <= ovf_q[g];
        tag_q[g+1] <= tag_q[g];
      end
    end

    if (g < QW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          r_q[g+1]    <= take ? diff[DW-1:0] : trial[DW-1:0];
          nlow_q[g+1] <= {nlow_q[g][QW-2:0], 1'b0};
          d_q[g+1]    <= d_q[g];
        end
      end
    end
  end

  assign q       = ovf_q[QW] ? {QW{1'b1}} : q_q[QW];
  assign tag_out = tag_q[QW];

endmodule

// ===== src/orbital_eccentricity_from_state_top.sv =====
// ----------------------------------------------------------------------------
// orbital_eccentricity_from_state_top: eccentricity magnitude from r and v
// Forms h = r x v and e = (v x h)/mu - r/|r|, returns |e| in unsigned Q8.24.
// ----------------------------------------------------------------------------
// One state vector is taken every clock while the output is not stalled;
// it passes 3 + 62 + 6 + 35 + 4 + 33 register stages plus the output register,
// i.e. 3 + 62 + 6 + (QUO_W + 1) + 4 + 33 + 1. The depth is set by the 62-stage
// root of |r|^2, the 35-stage dividers and the 33-stage final root, each
// resolving one bit per stage. The whole pipeline holds while a finished
// result waits on m_tready, so no transaction is lost or repeated. A zero
// position or a zero mu gives 0xFFFFFFFF with the bad_input flag set.
module orbital_eccentricity_from_state_top import oefs_pkg::*; #(
  parameter int POS_FRAC_BITS = POS_FRAC_DEF,
  parameter int VEL_FRAC_BITS = VEL_FRAC_DEF,
  parameter int ECC_FRAC_BITS = ECC_FRAC_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z (32 bits each, lowest first)
  input  logic [191:0]  s_tdata,
  output logic          m_tvalid,
  input  logic          m_tready,
  // ecc_magnitude
  output logic [31:0]   m_tdata,
  // bad_input
  output logic          m_tuser,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [MU_W-1:0] cfg_data
);

  localparam int SH  = ECC_FRAC_BITS + MU_FRAC_BITS - POS_FRAC_BITS - 2 * VEL_FRAC_BITS;
  localparam int SHL = (SH > 0) ? SH : 0;
  localparam int SHR = (SH < 0) ? -SH : 0;

  localparam int H_W    = 2 * COMP_W + 1;
  localparam int PP_W   = COMP_W + 33;
  localparam int M_W    = PP_W + 32;
  localparam int A_W    = M_W + 1;
  localparam int NW1    = A_W + SHL;
  localparam int DW1    = MU_W + SHR;
  localparam int NW2    = COMP_W + ECC_FRAC_BITS + NORM_GUARD;
  localparam int SQ1_IW = 4 * COMP_W + 2 * NORM_GUARD - 2 * COMP_W;
  localparam int R_W    = SQ1_IW / 2;
  localparam int E_W    = QUO_W + 2;
  localparam int EM_W   = COMP_W + 1;
  localparam int SQ_W   = 2 * EM_W;
  localparam int ROOT_W = SQ_W / 2;

  localparam int ST_S   = 3;
  localparam int ST_R   = ST_S + R_W;
  localparam int ST_F   = ST_R + 6;
  localparam int ST_Q   = ST_F + QUO_W + 1;
  localparam int ST_SUM = ST_Q + 4;
  localparam int NST    = ST_SUM + ROOT_W;

  localparam logic [E_W-1:0] EM_CAP = E_W'(1) << COMP_W;

  logic en;
  logic [MU_W-1:0] mu;

  logic vld   [1:NST];
  logic bad_q [ST_S:NST];

  assign en        = !m_tvalid || m_tready;
  assign s_tready  = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mu <= MU_RESET;
    end else if (cfg_valid) begin
      mu <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= NST; k++) vld[k] <= 1'b0;
    end else if (en) begin
      vld[1] <= s_tvalid;
      for (int k = 2; k <= NST; k++) vld[k] <= vld[k-1];
    end
  end

  // input, squares, |r|^2
  comp_t p1 [0:2];
  comp_t v1 [0:2];
  comp_t p2 [0:2];
  comp_t v2 [0:2];
  logic [2*COMP_W-1:0] sq2 [0:2];
  comp_t p3 [0:2];
  comp_t v3 [0:2];
  logic [2*COMP_W-1:0] s3;
  logic [2*COMP_W-1:0] s_sum;

  assign s_sum = sq2[0] + sq2[1] + sq2[2];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p1[i]  <= comp_t'(s_tdata[COMP_W*i +: COMP_W]);
        v1[i]  <= comp_t'(s_tdata[COMP_W*(i+3) +: COMP_W]);
        sq2[i] <= 64'(p1[i] * p1[i]);
        p2[i]  <= p1[i];
        v2[i]  <= v1[i];
        p3[i]  <= p2[i];
        v3[i]  <= v2[i];
      end
      s3 <= s_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bad_q[ST_S] <= (s_sum == '0) || (mu == '0);
      for (int k = ST_S + 1; k <= NST; k++) bad_q[k] <= bad_q[k-1];
    end
  end

  // |r| scaled by 2^NORM_GUARD
  logic [R_W-1:0] r_root;

  oefs_sqrt #(.IW(SQ1_IW)) u_norm_root (
    .clk  (clk),
    .en   (en),
    .x    ({s3, {(2*NORM_GUARD){1'b0}}}),
    .root (r_root)
  );

  // hold r and v beside the root
  comp_t pd_p [0:R_W-1][0:2];
  comp_t pd_v [0:R_W-1][0:2];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pd_p[0][i] <= p3[i];
        pd_v[0][i] <= v3[i];
      end
      for (int k = 1; k < R_W; k++) begin
        pd_p[k] <= pd_p[k-1];
        pd_v[k] <= pd_v[k-1];
      end
    end
  end

  // h = r x v, then a = v x h, then magnitudes for the dividers
  comp_t pa_v [0:2];
  comp_t pb_v [0:2];
  comp_t pa_p [0:2];
  comp_t pb_p [0:2];
  comp_t pc_p [0:2];
  comp_t pd_pp [0:2];
  comp_t pe_p [0:2];
  logic [R_W-1:0] ra, rb, rc, rd, re, rf;

  logic signed [2*COMP_W-1:0] hpa [0:2];
  logic signed [2*COMP_W-1:0] hpb [0:2];
  logic signed [H_W-1:0]      h   [0:2];
  logic signed [PP_W-1:0]     t1l [0:2];
  logic signed [PP_W-1:0]     t1h [0:2];
  logic signed [PP_W-1:0]     t2l [0:2];
  logic signed [PP_W-1:0]     t2h [0:2];
  logic signed [M_W-1:0]      m1  [0:2];
  logic signed [M_W-1:0]      m2  [0:2];
  logic signed [A_W-1:0]      a   [0:2];
  logic [NW1-1:0]             n1  [0:2];
  logic [NW2-1:0]             n2  [0:2];
  logic                       sa  [0:2];
  logic                       sp  [0:2];
  logic [A_W-1:0]             amag [0:2];
  logic [COMP_W-1:0]          pmag [0:2];

  for (genvar i = 0; i < 3; i++) begin : g_lane
    localparam int I1 = (i + 1) % 3;
    localparam int I2 = (i + 2) % 3;

    assign amag[i] = a[i][A_W-1] ? A_W'(-a[i]) : A_W'(a[i]);
    assign pmag[i] = pe_p[i][COMP_W-1] ? COMP_W'(-pe_p[i]) : COMP_W'(pe_p[i]);

    always_ff @(posedge clk) begin
      if (en) begin
        hpa[i] <= pd_p[R_W-1][I1] * pd_v[R_W-1][I2];
        hpb[i] <= pd_p[R_W-1][I2] * pd_v[R_W-1][I1];
        h[i]   <= H_W'(hpa[i]) - H_W'(hpb[i]);
        t1l[i] <= pb_v[I1] * $signed({1'b0, h[I2][31:0]});
        t1h[i] <= pb_v[I1] * $signed(h[I2][H_W-1:32]);
        t2l[i] <= pb_v[I2] * $signed({1'b0, h[I1][31:0]});
        t2h[i] <= pb_v[I2] * $signed(h[I1][H_W-1:32]);
        m1[i]  <= $signed({t1h[i], 32'd0}) + M_W'(t1l[i]);
        m2[i]  <= $signed({t2h[i], 32'd0}) + M_W'(t2l[i]);
        a[i]   <= A_W'(m1[i]) - A_W'(m2[i]);
        n1[i]  <= NW1'(amag[i]) << SHL;
        sa[i]  <= a[i][A_W-1];
        n2[i]  <= NW2'(pmag[i]) << (ECC_FRAC_BITS + NORM_GUARD);
        sp[i]  <= pe_p[i][COMP_W-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa_v  <= pd_v[R_W-1];
      pa_p  <= pd_p[R_W-1];
      pb_v  <= pa_v;
      pb_p  <= pa_p;
      pc_p  <= pb_p;
      pd_pp <= pc_p;
      pe_p  <= pd_pp;
      ra    <= r_root;
      rb    <= ra;
      rc    <= rb;
      rd    <= rc;
      re    <= rd;
      rf    <= re;
    end
  end

  // both quotients per component, then the difference and its square
  logic [QUO_W-1:0] q1 [0:2];
  logic [QUO_W-1:0] q2 [0:2];
  logic             g1 [0:2];
  logic             g2 [0:2];
  logic signed [E_W-1:0] t1s [0:2];
  logic signed [E_W-1:0] t2s [0:2];
  logic signed [E_W-1:0] e   [0:2];
  logic [E_W-1:0]        emag [0:2];
  logic [EM_W-1:0]       em  [0:2];
  logic [SQ_W-1:0]       esq [0:2];
  logic [SQ_W-1:0]       esum;

  for (genvar i = 0; i < 3; i++) begin : g_quo
    oefs_div #(.NW(NW1), .DW(DW1), .QW(QUO_W), .TW(1)) u_div_mu (
      .clk     (clk),
      .en      (en),
      .n       (n1[i]),
      .d       (DW1'(mu) << SHR),
      .tag_in  (sa[i]),
      .q       (q1[i]),
      .tag_out (g1[i])
    );

    oefs_div #(.NW(NW2), .DW(R_W), .QW(QUO_W), .TW(1)) u_div_norm (
      .clk     (clk),
      .en      (en),
      .n       (n2[i]),
      .d       (rf),
      .tag_in  (sp[i]),
      .q       (q2[i]),
      .tag_out (g2[i])
    );

    assign t1s[i]  = g1[i] ? -$signed(E_W'(q1[i])) : $signed(E_W'(q1[i]));
    assign t2s[i]  = g2[i] ? -$signed(E_W'(q2[i])) : $signed(E_W'(q2[i]));
    assign emag[i] = e[i][E_W-1] ? E_W'(-e[i]) : E_W'(e[i]);

    always_ff @(posedge clk) begin
      if (en) begin
        e[i]   <= t1s[i] - t2s[i];
        em[i]  <= (emag[i] > EM_CAP) ? EM_W'(EM_CAP) : EM_W'(emag[i]);
        esq[i] <= em[i] * em[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      esum <= esq[0] + esq[1] + esq[2];
    end
  end

  logic [ROOT_W-1:0] ecc_root;

  oefs_sqrt #(.IW(SQ_W)) u_ecc_root (
    .clk  (clk),
    .en   (en),
    .x    (esum),
    .root (ecc_root)
  );

  // output register: saturate, and force all ones on a bad transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= vld[NST];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tuser <= bad_q[NST];
      if (bad_q[NST] || ecc_root[ROOT_W-1]) begin
        m_tdata <= '1;
      end else begin
        m_tdata <= ecc_root[COMP_W-1:0];
      end
    end
  end

endmodule
